[hw/rtl/lobm_pkg.sv]
package lobm_pkg;

    localparam int TICKER_W     = 6;
    localparam int LEVEL_W      = 10;
    localparam int PRICE_W      = 17;
    localparam int QTY_W        = 16;
    localparam int SLOT_W       = 12;
    localparam int CNT_W        = SLOT_W + 1;
    localparam int LVL_ADDR_W   = TICKER_W + 1 + LEVEL_W;
    localparam int FILLS_W      = 6;
    localparam int APB_ADDR_W   = 2;

    localparam logic [CNT_W-1:0]   ORDER_SLOTS     = CNT_W'(1 << SLOT_W);
    localparam logic [FILLS_W-1:0] MAX_FILLS       = FILLS_W'(62);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = '1;
    localparam logic [LEVEL_W-1:0] PRICE_LIMIT_RST = LEVEL_W'(999);

    localparam logic [APB_ADDR_W-1:0] REG_PRICE_LIMIT = '0;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [2:0] {
        KIND_ACCEPT   = 3'd0,
        KIND_REJ_ARGS = 3'd1,
        KIND_REJ_FULL = 3'd2,
        KIND_TRADE    = 3'd3,
        KIND_FILL_LIM = 3'd4
    } kind_t;

    typedef struct packed {
        logic [TICKER_W-1:0] ticker;
        logic                side;
        logic [QTY_W-1:0]    quantity;
        logic [PRICE_W-1:0]  price;
    } order_t;

    typedef struct packed {
        kind_t               kind;
        logic [PRICE_W-1:0]  bid_price;
        logic [PRICE_W-1:0]  ask_price;
        logic [QTY_W-1:0]    fill_quantity;
        logic                last;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } level_entry_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [SLOT_W-1:0]  link;
    } slot_entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ALLOC_WR,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_SB_RD,
        ST_SB_CK,
        ST_SS_RD,
        ST_SS_CK,
        ST_MATCH,
        ST_RD_S,
        ST_CMP,
        ST_WB_S,
        ST_FIN
    } state_t;

endpackage

[hw/rtl/lobm_ram.sv]
module lobm_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/lobm_cfg.sv]
module lobm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lobm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [lobm_pkg::LEVEL_W-1:0]   price_limit
);
    import lobm_pkg::*;

    logic [LEVEL_W-1:0] price_limit_reg;
    logic               wr_en;

    assign wr_en = psel && penable && pwrite && (paddr == REG_PRICE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            price_limit_reg <= PRICE_LIMIT_RST;
        end
        else if (wr_en)
        begin
            price_limit_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_PRICE_LIMIT)
        begin
            prdata = {{(32 - LEVEL_W){1'b0}}, price_limit_reg};
        end
    end

    assign pready      = 1'b1;
    assign price_limit = price_limit_reg;

endmodule

[hw/rtl/lobm_engine.sv]
module lobm_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lobm_pkg::order_t             order,
    input  logic [lobm_pkg::LEVEL_W-1:0] price_limit,
    output logic                         busy,
    output logic                         result_valid,
    output lobm_pkg::result_t            result
);
    import lobm_pkg::*;

    state_t state_reg, state_next;

    // memory ports
    logic                  lvl_we;
    logic [LVL_ADDR_W-1:0] lvl_addr;
    level_entry_t          lvl_wdata, lvl_rdata;
    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_addr;
    slot_entry_t           slot_wdata, slot_rdata;

    logic [LVL_ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    order_t                ord_reg, ord_next;
    logic [SLOT_W-1:0]     free_head_reg, free_head_next;
    logic [CNT_W-1:0]      free_count_reg, free_count_next;
    logic [CNT_W-1:0]      fresh_reg, fresh_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic [LEVEL_W-1:0]    hb_reg, hb_next, ls_reg, ls_next;
    logic                  b_ok_reg, b_ok_next, s_ok_reg, s_ok_next;
    logic                  need_s_reg, need_s_next;
    logic                  b_pop_reg, b_pop_next, s_pop_reg, s_pop_next;
    level_entry_t          b_lvl_reg, b_lvl_next, s_lvl_reg, s_lvl_next;
    slot_entry_t           b_slot_reg, b_slot_next, s_slot_reg, s_slot_next;
    logic [FILLS_W-1:0]    fills_reg, fills_next;
    result_t               pend_reg, pend_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [LEVEL_W-1:0]    ord_lvl;
    logic                  alloc_fresh;
    logic [QTY_W-1:0]      trade_q;
    logic [QTY_W-1:0]      b_left;
    result_t               new_res;
    logic                  new_emit;

    assign ord_lvl     = ord_reg.price[PRICE_W-1:PRICE_W-LEVEL_W];
    assign alloc_fresh = ({1'b0, free_head_reg} >= fresh_reg);
    assign trade_q     = (b_slot_reg.qty < slot_rdata.qty) ? b_slot_reg.qty : slot_rdata.qty;
    assign b_left      = b_slot_reg.qty - trade_q;

    lobm_ram #(.ADDR_W(LVL_ADDR_W), .DATA_W($bits(level_entry_t))) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .addr  (lvl_addr),
        .wdata (lvl_wdata),
        .rdata (lvl_rdata)
    );

    lobm_ram #(.ADDR_W(SLOT_W), .DATA_W($bits(slot_entry_t))) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_head_reg  <= '0;
            free_count_reg <= ORDER_SLOTS;
            fresh_reg      <= '0;
            out_valid_reg  <= 1'b0;
            fills_reg      <= '0;
            b_ok_reg       <= 1'b0;
            s_ok_reg       <= 1'b0;
            need_s_reg     <= 1'b0;
            b_pop_reg      <= 1'b0;
            s_pop_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            out_valid_reg  <= out_valid_next;
            fills_reg      <= fills_next;
            b_ok_reg       <= b_ok_next;
            s_ok_reg       <= s_ok_next;
            need_s_reg     <= need_s_next;
            b_pop_reg      <= b_pop_next;
            s_pop_reg      <= s_pop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg    <= ord_next;
        tail_reg   <= tail_next;
        hb_reg     <= hb_next;
        ls_reg     <= ls_next;
        b_lvl_reg  <= b_lvl_next;
        s_lvl_reg  <= s_lvl_next;
        b_slot_reg <= b_slot_next;
        s_slot_reg <= s_slot_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        ord_next        = ord_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        tail_next       = tail_reg;
        hb_next         = hb_reg;
        ls_next         = ls_reg;
        b_ok_next       = b_ok_reg;
        s_ok_next       = s_ok_reg;
        need_s_next     = need_s_reg;
        b_pop_next      = b_pop_reg;
        s_pop_next      = s_pop_reg;
        b_lvl_next      = b_lvl_reg;
        s_lvl_next      = s_lvl_reg;
        b_slot_next     = b_slot_reg;
        s_slot_next     = s_slot_reg;
        fills_next      = fills_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = 1'b0;
        lvl_we          = 1'b0;
        lvl_addr        = {ord_reg.ticker, ord_reg.side, ord_lvl};
        lvl_wdata       = '0;
        slot_we         = 1'b0;
        slot_addr       = free_head_reg;
        slot_wdata      = '0;
        new_emit        = 1'b0;
        new_res         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                lvl_we       = 1'b1;
                lvl_addr     = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ord_next   = order;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // level and slot reads go out now for the append
                fills_next  = '0;
                hb_next     = LEVEL_MAX;
                ls_next     = '0;
                need_s_next = 1'b1;
                if ((ord_reg.quantity == '0) || (ord_lvl > price_limit))
                begin
                    new_emit      = 1'b1;
                    new_res.kind  = KIND_REJ_ARGS;
                    state_next    = ST_SB_RD;
                end
                else if (free_count_reg == '0)
                begin
                    new_emit      = 1'b1;
                    new_res.kind  = KIND_REJ_FULL;
                    state_next    = ST_SB_RD;
                end
                else
                begin
                    state_next = ST_ALLOC_WR;
                end
            end
            ST_ALLOC_WR:
            begin
                free_count_next = free_count_reg - 1'b1;
                if (alloc_fresh)
                begin
                    free_head_next = free_head_reg + 1'b1;
                    fresh_next     = fresh_reg + 1'b1;
                end
                else
                begin
                    free_head_next = slot_rdata.link;
                end
                slot_we          = 1'b1;
                slot_wdata.price = ord_reg.price;
                slot_wdata.qty   = ord_reg.quantity;
                lvl_we           = 1'b1;
                tail_next        = lvl_rdata.tail;
                new_emit         = 1'b1;
                new_res.kind     = KIND_ACCEPT;
                if (lvl_rdata.valid)
                begin
                    lvl_wdata        = lvl_rdata;
                    lvl_wdata.tail   = free_head_reg;
                    // new slot kept in the buy scratch link until the old tail is patched
                    b_slot_next.link = free_head_reg;
                    state_next       = ST_LINK_RD;
                end
                else
                begin
                    lvl_wdata.valid = 1'b1;
                    lvl_wdata.head  = free_head_reg;
                    lvl_wdata.tail  = free_head_reg;
                    state_next      = ST_SB_RD;
                end
            end
            ST_LINK_RD:
            begin
                slot_addr  = tail_reg;
                state_next = ST_LINK_WR;
            end
            ST_LINK_WR:
            begin
                // previous tail now points at the slot just taken
                slot_we         = 1'b1;
                slot_addr       = tail_reg;
                slot_wdata      = slot_rdata;
                slot_wdata.link = b_slot_reg.link;
                state_next      = ST_SB_RD;
            end
            ST_SB_RD:
            begin
                lvl_addr   = {ord_reg.ticker, SIDE_BUY, hb_reg};
                state_next = ST_SB_CK;
            end
            ST_SB_CK:
            begin
                if (lvl_rdata.valid)
                begin
                    b_ok_next  = 1'b1;
                    b_lvl_next = lvl_rdata;
                    state_next = need_s_reg ? ST_SS_RD : ST_MATCH;
                end
                else if (hb_reg == '0)
                begin
                    b_ok_next  = 1'b0;
                    state_next = need_s_reg ? ST_SS_RD : ST_MATCH;
                end
                else
                begin
                    hb_next    = hb_reg - 1'b1;
                    state_next = ST_SB_RD;
                end
            end
            ST_SS_RD:
            begin
                lvl_addr   = {ord_reg.ticker, SIDE_SELL, ls_reg};
                state_next = ST_SS_CK;
            end
            ST_SS_CK:
            begin
                need_s_next = 1'b0;
                if (lvl_rdata.valid)
                begin
                    s_ok_next  = 1'b1;
                    s_lvl_next = lvl_rdata;
                    state_next = ST_MATCH;
                end
                else if (ls_reg == LEVEL_MAX)
                begin
                    s_ok_next  = 1'b0;
                    state_next = ST_MATCH;
                end
                else
                begin
                    need_s_next = 1'b1;
                    ls_next     = ls_reg + 1'b1;
                    state_next  = ST_SS_RD;
                end
            end
            ST_MATCH:
            begin
                b_pop_next = 1'b0;
                s_pop_next = 1'b0;
                if (!b_ok_reg || !s_ok_reg || (hb_reg < ls_reg))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    slot_addr  = b_lvl_reg.head;
                    state_next = ST_RD_S;
                end
            end
            ST_RD_S:
            begin
                b_slot_next = slot_rdata;
                slot_addr   = s_lvl_reg.head;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                if (b_slot_reg.price < slot_rdata.price)
                begin
                    state_next = ST_FIN;
                end
                else if (fills_reg == MAX_FILLS)
                begin
                    new_emit     = 1'b1;
                    new_res.kind = KIND_FILL_LIM;
                    state_next   = ST_FIN;
                end
                else
                begin
                    new_emit              = 1'b1;
                    new_res.kind          = KIND_TRADE;
                    new_res.bid_price     = b_slot_reg.price;
                    new_res.ask_price     = slot_rdata.price;
                    new_res.fill_quantity = trade_q;
                    fills_next            = fills_reg + 1'b1;
                    s_slot_next           = slot_rdata;
                    s_slot_next.qty       = slot_rdata.qty - trade_q;
                    slot_we               = 1'b1;
                    slot_addr             = b_lvl_reg.head;
                    slot_wdata            = b_slot_reg;
                    slot_wdata.qty        = b_left;
                    if (b_left == '0)
                    begin
                        // buy head filled: unlink it and push it on the pool
                        b_pop_next      = 1'b1;
                        slot_wdata.link = free_head_reg;
                        free_head_next  = b_lvl_reg.head;
                        if (free_count_reg < ORDER_SLOTS)
                        begin
                            free_count_next = free_count_reg + 1'b1;
                        end
                        lvl_we   = 1'b1;
                        lvl_addr = {ord_reg.ticker, SIDE_BUY, hb_reg};
                        if (b_lvl_reg.head != b_lvl_reg.tail)
                        begin
                            lvl_wdata.valid = 1'b1;
                            lvl_wdata.head  = b_slot_reg.link;
                            lvl_wdata.tail  = b_lvl_reg.tail;
                        end
                    end
                    state_next = ST_WB_S;
                end
            end
            ST_WB_S:
            begin
                slot_we    = 1'b1;
                slot_addr  = s_lvl_reg.head;
                slot_wdata = s_slot_reg;
                if (s_slot_reg.qty == '0)
                begin
                    s_pop_next      = 1'b1;
                    slot_wdata.link = free_head_reg;
                    free_head_next  = s_lvl_reg.head;
                    if (free_count_reg < ORDER_SLOTS)
                    begin
                        free_count_next = free_count_reg + 1'b1;
                    end
                    lvl_we   = 1'b1;
                    lvl_addr = {ord_reg.ticker, SIDE_SELL, ls_reg};
                    if (s_lvl_reg.head != s_lvl_reg.tail)
                    begin
                        lvl_wdata.valid = 1'b1;
                        lvl_wdata.head  = s_slot_reg.link;
                        lvl_wdata.tail  = s_lvl_reg.tail;
                    end
                end
                need_s_next = (s_slot_reg.qty == '0);
                if (b_pop_reg)
                begin
                    state_next = ST_SB_RD;
                end
                else if (s_slot_reg.qty == '0)
                begin
                    state_next = ST_SS_RD;
                end
                else
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_FIN:
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // the held result goes out once the next one is known
        if (new_emit)
        begin
            if (state_reg != ST_CHECK && state_reg != ST_ALLOC_WR)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_next.last  = 1'b0;
            end
            pend_next = new_res;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_fills_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fills_reg <= MAX_FILLS)
        else $error("fill count past limit");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_count_reg <= ORDER_SLOTS) && (fresh_reg <= ORDER_SLOTS))
        else $error("slot pool count out of range");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == ST_IDLE) |=> (state_reg == ST_CHECK))
        else $error("accepted order not checked");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last) |=> !out_valid_reg)
        else $error("beat after final beat of an order");

    a_no_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !out_valid_reg)
        else $error("beat during clearing pass");

endmodule

[hw/rtl/limit_order_book_matcher_top.sv]
// limit order book matcher: each order (ticker, side, quantity, 10.7 fixed
// point price) is checked against price_limit, appended fifo to its
// ticker/side/price-level queue from a shared pool of 4096 slots, and then
// matching runs for that ticker. results leave as beats on result, with
// result_valid high for a single cycle per beat; the receiver cannot
// stall, so every beat must be taken as it appears. each order gives an
// acknowledgement beat, then up to 62 trade beats, then possibly a fill-limit
// beat; the final beat of an order carries last. busy stays high from the
// accept on and drops in the cycle that carries the last beat. after reset
// the block clears all 131072 entries of the level table (busy high, config
// writes taken). the single-port level and slot memories set the pace: an
// append reads then writes the level entry and slot, and the old tail too
// when the level holds orders; each level scanned is a read (up to 2048 per
// order for the first buy and sell scans); a trade reads both heads, then
// writes both back; emptied levels are rescanned; ST_FIN sends the last beat
module limit_order_book_matcher_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // order beat
    input  logic                            start,
    input  lobm_pkg::order_t                order,
    output logic                            busy,
    // result beats
    output logic                            result_valid,
    output lobm_pkg::result_t               result,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lobm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lobm_pkg::*;

    logic [LEVEL_W-1:0] price_limit;

    // register block
    lobm_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .price_limit (price_limit)
    );

    // book sequencer with level and slot memories
    lobm_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .order        (order),
        .price_limit  (price_limit),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
